>>> hdl/contraharmonic_mean_filter_3x3_top_assert.svh
`ifndef CONTRAHARMONIC_MEAN_FILTER_3X3_TOP_ASSERT_SVH
`define CONTRAHARMONIC_MEAN_FILTER_3X3_TOP_ASSERT_SVH

// Clocked property check, disabled in reset.
`define CMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define CMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cmf_pkg.sv
package cmf_pkg;

  localparam int Kernel   = 3;
  localparam int LogFrac  = 16;
  localparam int ExpSteps = 20;
  localparam int TW       = 28;  // exponent q*log2(x), signed
  localparam int DW       = 29;  // exponent difference, unsigned
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_Q_SIXTEENTHS = 2'd2;

  typedef struct packed {
    logic [7:0] pix_ch2;
    logic [7:0] pix_ch1;
    logic [7:0] pix_ch0;
  } pix_t;

  typedef struct packed {
    logic [7:0]  out_ch0;
    logic [7:0]  out_ch1;
    logic [7:0]  out_ch2;
    logic [11:0] centre_row;
    logic [9:0]  centre_col;
    logic        frame_done;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef logic [18:0] log_t;
  typedef log_t log_tab_t [256];
  typedef logic [29:0] root_t;
  typedef root_t root_tab_t [ExpSteps+1];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    rem   = v;
    res   = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] m;
    int          n;
    logic [15:0] frac;
    tab[0] = '0;
    for (int x = 1; x < 256; x++) begin
      n = 0;
      while ((x >> (n + 1)) != 0) n++;
      m    = 64'(x) << (30 - n);
      frac = '0;
      for (int i = 0; i < LogFrac; i++) begin
        m    = (m * m) >> 30;
        frac = {frac[14:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          frac[0] = 1'b1;
          m       = m >> 1;
        end
      end
      tab[x] = {3'(n), frac};
    end
    return tab;
  endfunction

  function automatic root_tab_t build_root_tab();
    root_tab_t   tab;
    logic [63:0] r;
    tab[0] = '0;
    r      = int_sqrt(64'd1 << 59);
    tab[1] = 30'(r);
    for (int i = 2; i <= ExpSteps; i++) begin
      r      = int_sqrt(r << 30);
      tab[i] = 30'(r);
    end
    return tab;
  endfunction

endpackage

>>> hdl/cmf_stream_if.sv
interface cmf_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/cmf_ram.sv
module cmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cmf_exp_unit.sv
module cmf_exp_unit #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cmf_pkg::DW-1:0]    d_i,
  output cmf_pkg::unit_stat_t       stat_o,
  output logic [WEIGHT_BITS:0]      w_o
);

  localparam cmf_pkg::root_tab_t RootTab = cmf_pkg::build_root_tab();

  logic                 busy_q;
  logic                 done_q;
  logic [4:0]           cnt_q;
  logic [30:0]          m_q;
  logic [19:0]          f_q;
  logic [8:0]           n_q;
  logic [WEIGHT_BITS:0] w_q;

  logic [4:0]           root_idx;
  logic [60:0]          prod;
  logic [30:0]          m_next;
  logic [9:0]           s_c;
  logic [41:0]          rnd;
  logic [41:0]          shifted;
  logic [WEIGHT_BITS:0] w_c;

  assign root_idx = (cnt_q < 5'(cmf_pkg::ExpSteps)) ? cnt_q + 5'd1 : 5'(cmf_pkg::ExpSteps);
  assign prod     = 61'(m_q) * 61'(RootTab[root_idx]) + (61'd1 << 29);
  assign m_next   = prod[60:30];
  assign s_c      = 10'(30 - WEIGHT_BITS) + 10'(n_q);
  assign rnd      = 42'(m_q) + (42'd1 << (s_c - 10'd1));
  assign shifted  = rnd >> s_c;
  assign w_c      = (s_c > 10'd40) ? '0 : shifted[WEIGHT_BITS:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        m_q    <= 31'h4000_0000;
        f_q    <= d_i[19:0];
        n_q    <= d_i[28:20];
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q < 5'(cmf_pkg::ExpSteps)) begin
          if (f_q[19]) begin
            m_q <= m_next;
          end
          f_q   <= {f_q[18:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
        end else begin
          w_q    <= w_c;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign w_o         = w_q;

endmodule

>>> hdl/cmf_div_unit.sv
module cmf_div_unit #(
  parameter int NW = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NW-1:0]       dividend_i,
  input  logic [NW-1:0]       divisor_i,
  output cmf_pkg::unit_stat_t stat_o,
  output logic [8:0]          quot_o
);

  logic          busy_q;
  logic          done_q;
  logic [3:0]    cnt_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] ds_q;
  logic [8:0]    quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i;
        ds_q   <= divisor_i << 8;
        quot_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= ds_q) begin
          rem_q  <= rem_q - ds_q;
          quot_q <= {quot_q[7:0], 1'b1};
        end else begin
          quot_q <= {quot_q[7:0], 1'b0};
        end
        ds_q <= ds_q >> 1;
        if (cnt_q == 4'd8) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

>>> hdl/contraharmonic_mean_filter_3x3_top.sv
// Border pixel: accepted in S_IDLE, shifted into the window in S_SHIFT, then the next one is taken.
// Interior pixel: per channel a log step for each of the nine window pixels, an exp2 weight
// per used pixel (20-step iteration on one 31x30 multiplier), a pass over each skipped pixel
// and the divider; one pixel at a time.
// Async active-low reset clears counters, window and handshakes, and sets the
// size/order registers to 640, 480 and 24; the line buffers are not cleared.
module contraharmonic_mean_filter_3x3_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cmf_stream_if.sink                     pix_i,
  cmf_stream_if.source                   res_o,
  input  logic                           cfg_we_i,
  input  logic [cmf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cmf_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WTW  = WEIGHT_BITS + 1;
  localparam int NUMW = WTW + 12;
  localparam int DENW = WTW + 4;
  localparam int NW   = WTW + 14;
  localparam cmf_pkg::log_tab_t LogTab = cmf_pkg::build_log_tab();

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_LOG, S_DIFF, S_EXP, S_DIVST, S_DIV, S_NEXT, S_OUT
  } state_e;

  state_e state_q;

  logic [10:0]             width_q;
  logic [11:0]             height_q;
  logic signed [8:0]       q_q;
  logic [CW-1:0]           col_q;
  logic [11:0]             row_q;
  cmf_pkg::pix_t           pix_q;
  logic [23:0]             win_q [9];
  logic signed [cmf_pkg::TW-1:0] t_q [9];
  logic [8:0]              use_q;
  logic signed [cmf_pkg::TW-1:0] tmax_q;
  logic                    any_q;
  logic                    zero_q;
  logic [3:0]              idx_q;
  logic [1:0]              ch_q;
  logic [NUMW-1:0]         num_q;
  logic [DENW-1:0]         den_q;
  logic [7:0]              res_q [3];
  logic [11:0]             crow_q;
  logic [9:0]              ccol_q;
  logic                    fdone_q;
  logic                    out_valid_q;
  cmf_pkg::res_t           out_q;

  logic [12:0]             w_in;
  logic [12:0]             w_eff;
  logic [11:0]             h_eff;
  logic [12:0]             c_ext;
  logic [12:0]             c_m1;
  logic [12:0]             c_p1;
  logic [11:0]             r_p1;
  logic [11:0]             r_m1;
  logic                    interior;
  logic                    in_acc;
  logic [23:0]             rd0;
  logic [23:0]             rd1;
  logic [7:0]              x_c;
  logic signed [cmf_pkg::TW-1:0] q_ext;
  logic signed [cmf_pkg::TW-1:0] lg_ext;
  logic signed [cmf_pkg::TW-1:0] t_c;
  logic                    use_c;
  logic                    zero_c;
  logic signed [cmf_pkg::TW:0]   diff_c;
  logic                    exp_start;
  logic                    div_start;
  logic [WTW-1:0]          w_val;
  logic [8:0]              quot;
  cmf_pkg::unit_stat_t     exp_stat;
  cmf_pkg::unit_stat_t     div_stat;
  logic [NW-1:0]           div_n;
  logic [NW-1:0]           div_d;

  assign w_in  = 13'(width_q);
  assign w_eff = (w_in < 13'(cmf_pkg::Kernel)) ? 13'(cmf_pkg::Kernel) :
                 (w_in > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : w_in;
  assign h_eff = (height_q < 12'(cmf_pkg::Kernel)) ? 12'(cmf_pkg::Kernel) : height_q;
  assign c_ext = 13'(col_q);
  assign c_m1  = c_ext - 13'd1;
  assign c_p1  = c_ext + 13'd1;
  assign r_p1  = row_q + 12'd1;
  assign r_m1  = row_q - 12'd1;
  assign interior = (row_q >= 12'(cmf_pkg::Kernel - 1)) &&
                    (c_ext >= 13'(cmf_pkg::Kernel - 1));

  assign pix_i.ready = (state_q == S_IDLE);
  assign in_acc      = pix_i.valid && pix_i.ready;

  cmf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SHIFT),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (rd0)
  );

  cmf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SHIFT),
    .waddr_i (col_q),
    .wdata_i (rd0),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (rd1)
  );

  assign x_c    = win_q[idx_q][{ch_q, 3'b000} +: 8];
  assign q_ext  = cmf_pkg::TW'(q_q);
  assign lg_ext = cmf_pkg::TW'(signed'({1'b0, LogTab[x_c]}));
  assign t_c    = q_ext * lg_ext;
  assign use_c  = !((x_c == 8'd0) && (q_q > 9'sd0));
  assign zero_c = zero_q || (x_c == 8'd0);
  assign diff_c = {tmax_q[cmf_pkg::TW-1], tmax_q} - {t_q[idx_q][cmf_pkg::TW-1], t_q[idx_q]};

  assign exp_start = (state_q == S_DIFF) && use_q[idx_q];
  assign div_start = (state_q == S_DIVST) && (den_q != '0);
  assign div_n     = (NW'(num_q) << 1) + NW'(den_q);
  assign div_d     = NW'(den_q) << 1;

  cmf_exp_unit #(.WEIGHT_BITS(WEIGHT_BITS)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .d_i     (cmf_pkg::DW'(unsigned'(diff_c))),
    .stat_o  (exp_stat),
    .w_o     (w_val)
  );

  cmf_div_unit #(.NW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 11'd640;
      height_q    <= 12'd480;
      q_q         <= 9'sd24;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      use_q       <= '0;
      any_q       <= 1'b0;
      zero_q      <= 1'b0;
      idx_q       <= '0;
      ch_q        <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (res_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            pix_q   <= pix_i.payload;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int k = 0; k < 3; k++) begin
            win_q[k*3]   <= win_q[k*3+1];
            win_q[k*3+1] <= win_q[k*3+2];
          end
          win_q[2] <= rd1;
          win_q[5] <= rd0;
          win_q[8] <= pix_q;
          crow_q   <= r_m1;
          ccol_q   <= c_m1[9:0];
          fdone_q  <= (row_q == h_eff - 12'd1) && (c_p1 == w_eff);
          if (c_p1 >= w_eff) begin
            col_q <= '0;
            row_q <= (r_p1 >= h_eff) ? 12'd0 : r_p1;
          end else begin
            col_q <= CW'(c_p1);
          end
          ch_q   <= '0;
          idx_q  <= '0;
          any_q  <= 1'b0;
          zero_q <= 1'b0;
          tmax_q <= '0;
          state_q <= interior ? S_LOG : S_IDLE;
        end
        S_LOG: begin
          t_q[idx_q]   <= t_c;
          use_q[idx_q] <= use_c;
          zero_q       <= zero_c;
          if (use_c && (!any_q || t_c > tmax_q)) begin
            tmax_q <= t_c;
            any_q  <= 1'b1;
          end
          if (idx_q == 4'd8) begin
            idx_q <= '0;
            num_q <= '0;
            den_q <= '0;
            if ((q_q < 9'sd0) && zero_c) begin
              res_q[ch_q] <= '0;
              state_q     <= S_NEXT;
            end else begin
              state_q <= S_DIFF;
            end
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        S_DIFF: begin
          if (use_q[idx_q]) begin
            state_q <= S_EXP;
          end else if (idx_q == 4'd8) begin
            state_q <= S_DIVST;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        S_EXP: begin
          if (exp_stat.done) begin
            den_q <= den_q + DENW'(w_val);
            num_q <= num_q + NUMW'(w_val) * NUMW'(x_c);
            if (idx_q == 4'd8) begin
              state_q <= S_DIVST;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= S_DIFF;
            end
          end
        end
        S_DIVST: begin
          if (den_q == '0) begin
            res_q[ch_q] <= '0;
            state_q     <= S_NEXT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_q[ch_q] <= quot[7:0];
            state_q     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (ch_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            ch_q    <= ch_q + 2'd1;
            idx_q   <= '0;
            any_q   <= 1'b0;
            zero_q  <= 1'b0;
            tmax_q  <= '0;
            state_q <= S_LOG;
          end
        end
        S_OUT: begin
          if (!out_valid_q || res_o.ready) begin
            out_q.out_ch0    <= res_q[0];
            out_q.out_ch1    <= res_q[1];
            out_q.out_ch2    <= res_q[2];
            out_q.centre_row <= crow_q;
            out_q.centre_col <= ccol_q;
            out_q.frame_done <= fdone_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cmf_pkg::CFG_IMAGE_WIDTH: begin
            width_q <= cfg_data_i[10:0];
            col_q   <= '0;
            row_q   <= '0;
          end
          cmf_pkg::CFG_IMAGE_HEIGHT: begin
            height_q <= cfg_data_i[11:0];
            col_q    <= '0;
            row_q    <= '0;
          end
          cmf_pkg::CFG_Q_SIXTEENTHS: q_q <= signed'(cfg_data_i[8:0]);
          default: ;
        endcase
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

>>> hdl/cmf_checker.sv
`include "contraharmonic_mean_filter_3x3_top_assert.svh"

module cmf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input cmf_pkg::res_t out_payload_i
);

  `CMF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result request dropped while stalled")
  `CMF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_payload_i), "stalled result changed")
  `CMF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "pixel taken while previous one still in work")
  `CMF_ASSERT(a_interior_only, clk_i, rst_ni, !out_valid_i || (out_payload_i.centre_row != 12'd0 && out_payload_i.centre_col != 10'd0), "border position in result")

endmodule

bind contraharmonic_mean_filter_3x3_top cmf_checker u_cmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_payload_i (res_o.payload)
);

>>> sim/contraharmonic_mean_filter_3x3_top_tb.sv
module contraharmonic_mean_filter_3x3_top_tb;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [cmf_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [cmf_pkg::CfgDataW-1:0] cfg_data_i;

  cmf_stream_if #(.T(cmf_pkg::pix_t)) pix_if ();
  cmf_stream_if #(.T(cmf_pkg::res_t)) res_if ();

  contraharmonic_mean_filter_3x3_top u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pix_i(pix_if.sink),
    .res_o(res_if.source),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [18:0] log2_lut [256];
  longint unsigned sqrt_step [cmf_pkg::ExpSteps+1];
  logic [10:0] img_w_reg;
  logic [11:0] img_h_reg;
  int q_order;
  logic [23:0] line_buf [2][1024];
  logic [23:0] win [9];
  int unsigned row_cnt, col_cnt;

  cmf_pkg::pix_t pending_pix [$];
  cmf_pkg::res_t expected_res [$];
  int send_idle_pct, recv_stall_pct;
  int errors, n_requests, n_results, n_phases;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_luts();
    longint unsigned m;
    int n;
    logic [15:0] frac;
    log2_lut[0] = '0;
    for (int x = 1; x < 256; x++) begin
      n = 0;
      while ((x >> (n + 1)) != 0) n++;
      m = longint'(x) << (30 - n);
      frac = '0;
      for (int i = 0; i < cmf_pkg::LogFrac; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      log2_lut[x] = {n[2:0], frac};
    end
    sqrt_step[0] = 0;
    sqrt_step[1] = floor_sqrt(64'd1 << 59);
    for (int i = 2; i <= cmf_pkg::ExpSteps; i++)
      sqrt_step[i] = floor_sqrt(sqrt_step[i-1] << 30);
  endfunction

  function automatic longint unsigned exp2_weight(longint unsigned d);
    longint unsigned n, f, m, s;
    n = d >> cmf_pkg::ExpSteps;
    f = d & ((64'd1 << cmf_pkg::ExpSteps) - 1);
    m = 64'd1 << 30;
    for (int i = 1; i <= cmf_pkg::ExpSteps; i++)
      if ((f >> (cmf_pkg::ExpSteps - i)) & 1) m = (m * sqrt_step[i] + (64'd1 << 29)) >> 30;
    s = 14 + n;
    if (s > 40) return 0;
    return (m + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [7:0] chm_channel(int sh);
    longint t [9];
    longint tmax;
    bit used [9];
    bit any, zero;
    longint unsigned num, den, w;
    int x;
    tmax = 0; any = 0; zero = 0; num = 0; den = 0;
    for (int i = 0; i < 9; i++) begin
      x = (win[i] >> sh) & 8'hFF;
      used[i] = 1;
      t[i] = 0;
      if (x == 0) begin
        zero = 1;
        if (q_order > 0) used[i] = 0;
      end else begin
        t[i] = longint'(q_order) * longint'(log2_lut[x]);
      end
      if (used[i] && (!any || t[i] > tmax)) begin
        tmax = t[i];
        any = 1;
      end
    end
    if (q_order < 0 && zero) return 8'd0;
    for (int i = 0; i < 9; i++) begin
      if (used[i]) begin
        w = exp2_weight(longint'(tmax - t[i]));
        den += w;
        num += w * ((win[i] >> sh) & 8'hFF);
      end
    end
    if (den == 0) return 8'd0;
    return 8'((2 * num + den) / (2 * den));
  endfunction

  function automatic void filter_pixel(cmf_pkg::pix_t p);
    int unsigned w, h, c, r;
    logic [23:0] colv [3];
    cmf_pkg::res_t e;
    w = img_w_reg;
    h = img_h_reg;
    if (w < 3) w = 3;
    if (w > 1024) w = 1024;
    if (h < 3) h = 3;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    colv[1] = line_buf[0][c];
    colv[0] = line_buf[1][c];
    colv[2] = p;
    line_buf[1][c] = line_buf[0][c];
    line_buf[0][c] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
      win[k*3+2] = colv[k];
    end
    if (r >= 2 && c >= 2) begin
      e.out_ch0 = chm_channel(0);
      e.out_ch1 = chm_channel(8);
      e.out_ch2 = chm_channel(16);
      e.centre_row = 12'(r - 1);
      e.centre_col = 10'(c - 1);
      e.frame_done = (r == h - 1 && c == w - 1);
      expected_res.push_back(e);
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pending_pix.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_if.payload <= pending_pix.pop_front();
        pix_if.valid <= 1'b1;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        filter_pixel(pix_if.payload);
        n_requests++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (expected_res.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          cmf_pkg::res_t e, g;
          e = expected_res.pop_front();
          g = res_if.payload;
          if (g.out_ch0 !== e.out_ch0) report_mismatch("out_ch0", g.out_ch0, e.out_ch0);
          if (g.out_ch1 !== e.out_ch1) report_mismatch("out_ch1", g.out_ch1, e.out_ch1);
          if (g.out_ch2 !== e.out_ch2) report_mismatch("out_ch2", g.out_ch2, e.out_ch2);
          if (g.centre_row !== e.centre_row)
            report_mismatch("centre_row", g.centre_row, e.centre_row);
          if (g.centre_col !== e.centre_col)
            report_mismatch("centre_col", g.centre_col, e.centre_col);
          if (g.frame_done !== e.frame_done)
            report_mismatch("frame_done", g.frame_done, e.frame_done);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_pix.size() > 0 || pix_if.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [cmf_pkg::CfgIdxW-1:0] idx,
                           logic [cmf_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      cmf_pkg::CFG_IMAGE_WIDTH: begin
        img_w_reg = val[10:0];
        row_cnt = 0;
        col_cnt = 0;
      end
      cmf_pkg::CFG_IMAGE_HEIGHT: begin
        img_h_reg = val[11:0];
        row_cnt = 0;
        col_cnt = 0;
      end
      cmf_pkg::CFG_Q_SIXTEENTHS: q_order = $signed(val[8:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 15) return 8'd255;
    if (r < 20) return 8'd1;
    return 8'($urandom_range(255));
  endfunction

  function automatic cmf_pkg::pix_t rand_pix();
    cmf_pkg::pix_t p;
    p.pix_ch0 = rand_chan();
    p.pix_ch1 = rand_chan();
    p.pix_ch2 = rand_chan();
    return p;
  endfunction

  // one configuration, n random pixels, idling picked by phase number
  task automatic run_phase(int w, int h, int q, int n);
    wait_drained();
    case (n_phases % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 69; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 69; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
    n_phases++;
    write_reg(cmf_pkg::CFG_IMAGE_WIDTH, 12'(w));
    write_reg(cmf_pkg::CFG_IMAGE_HEIGHT, 12'(h));
    write_reg(cmf_pkg::CFG_Q_SIXTEENTHS, 12'(q));
    for (int i = 0; i < n; i++) pending_pix.push_back(rand_pix());
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.payload = '0;
    res_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = cmf_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    errors = 0;
    n_requests = 0;
    n_results = 0;
    n_phases = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    build_luts();
    img_w_reg = 11'd640;
    img_h_reg = 12'd480;
    q_order = 24;
    row_cnt = 0;
    col_cnt = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < 1024; i++) begin
      line_buf[0][i] = '0;
      line_buf[1][i] = '0;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 4x4 frame with extremes, zero pixels and a flat window
    write_reg(cmf_pkg::CFG_IMAGE_WIDTH, 12'd4);
    write_reg(cmf_pkg::CFG_IMAGE_HEIGHT, 12'd4);
    write_reg(cmf_pkg::CFG_Q_SIXTEENTHS, 12'(-24));
    for (int i = 0; i < 16; i++) begin
      cmf_pkg::pix_t p;
      p.pix_ch0 = (i == 5) ? 8'd0 : 8'd255;
      p.pix_ch1 = (i % 2) ? 8'd0 : 8'd255;
      p.pix_ch2 = 8'd77;
      pending_pix.push_back(p);
    end
    wait_drained();
    write_reg(cmf_pkg::CFG_Q_SIXTEENTHS, 12'd0);
    for (int i = 0; i < 9; i++)
      pending_pix.push_back(cmf_pkg::pix_t'({8'd0, 8'(i * 31), 8'd0}));

    // random phases across sizes and orders, extremes included
    run_phase(3, 3, 128, 27);
    run_phase(3, 3, -128, 27);
    run_phase(2, 0, 0, 27);
    run_phase(5, 4, 16, 40);
    run_phase(7, 5, -16, 35);
    run_phase(6, 6, 24, 36);
    run_phase(4, 3, -1, 24);
    run_phase(3, 4095, 1, 30);
    run_phase(8, 3, -77, 48);
    run_phase(2047, 3, 100, 40);
    run_phase(5, 5, $urandom_range(256) - 128, 50);
    run_phase(4, 6, $urandom_range(256) - 128, 24);
    run_phase(1024, 3, 255 - 512, 40);
    run_phase(3, 5, -100, 30);
    run_phase(6, 4, 64, 24);
    wait_drained();
    repeat (2000) @(posedge clk_i);
    $display("covered %0d pixel requests and %0d filtered results over %0d settings",
             n_requests, n_results, n_phases + 1);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, expected_res.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cmf_pkg.sv
hdl/cmf_stream_if.sv
hdl/cmf_ram.sv
hdl/cmf_exp_unit.sv
hdl/cmf_div_unit.sv
hdl/contraharmonic_mean_filter_3x3_top.sv
hdl/cmf_checker.sv
sim/contraharmonic_mean_filter_3x3_top_tb.sv
